/* hw/rtl/fud8_pkg.sv */
// Package: types, constants and helper functions of the form-value decoder.
`default_nettype none
package fud8_pkg;

	// input operation codes
	localparam logic OP_DATA = 1'b0;
	localparam logic OP_END  = 1'b1;

	// characters of the encoding
	localparam logic [7:0] CH_PERCENT = 8'h25;
	localparam logic [7:0] CH_PLUS    = 8'h2B;
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_DIG_LO  = 8'h30;
	localparam logic [7:0] CH_DIG_HI  = 8'h39;
	localparam logic [7:0] CH_UCA_LO  = 8'h41;
	localparam logic [7:0] CH_UCA_HI  = 8'h46;
	localparam logic [7:0] CH_LCA_LO  = 8'h61;
	localparam logic [7:0] CH_LCA_HI  = 8'h66;
	localparam logic [3:0] HEX_ALPHA_ADJ = 4'd9;

	// UTF-8 byte classes
	localparam logic [7:0] UTF_CONT_MASK  = 8'hC0;
	localparam logic [7:0] UTF_CONT       = 8'h80;
	localparam logic [7:0] UTF_LEAD2_MASK = 8'hE0;
	localparam logic [7:0] UTF_LEAD2      = 8'hC0;
	localparam logic [7:0] UTF_LEAD2_MIN  = 8'hC2;
	localparam logic [7:0] UTF_LEAD3_MASK = 8'hF0;
	localparam logic [7:0] UTF_LEAD3      = 8'hE0;
	localparam logic [7:0] UTF_LEAD4_MASK = 8'hF8;
	localparam logic [7:0] UTF_LEAD4      = 8'hF0;

	// continuation counts
	localparam logic [1:0] PEND_NONE = 2'd0;
	localparam logic [1:0] PEND_ONE  = 2'd1;
	localparam logic [1:0] PEND_TWO  = 2'd2;
	localparam logic [1:0] PEND_THR  = 2'd3;

	// sticky decode error codes
	localparam logic [1:0] DERR_NONE = 2'd0;
	localparam logic [1:0] DERR_ESC  = 2'd1;
	localparam logic [1:0] DERR_ZERO = 2'd2;

	// end status codes
	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_ESC  = 2'd1;
	localparam logic [1:0] ST_ZERO = 2'd2;
	localparam logic [1:0] ST_UTF8 = 2'd3;

	// escape phase
	typedef enum logic [1:0] {
		ESC_NONE = 2'd0,
		ESC_PCT  = 2'd1,
		ESC_HI   = 2'd2
	} esc_t;

	// per-value decoder state
	typedef struct packed {
		esc_t       esc;
		logic [3:0] hi;
		logic [1:0] pend;
		logic [1:0] derr;
		logic       uerr;
	} state_t;

	// one result item
	typedef struct packed {
		logic [7:0] out_byte;
		logic       has_byte;
		logic       done_res;
		logic [1:0] status;
	} res_t;

	// hex digit value: bit 4 marks a valid digit
	function automatic logic [4:0] hex_value(input logic [7:0] c);
		logic [4:0] r;
		begin
			r = '0;
			if (c >= CH_DIG_LO && c <= CH_DIG_HI) begin
				r = {1'b1, c[3:0]};
			end else if ((c >= CH_LCA_LO && c <= CH_LCA_HI) ||
			             (c >= CH_UCA_LO && c <= CH_UCA_HI)) begin
				r = {1'b1, 4'(c[3:0] + HEX_ALPHA_ADJ)};
			end
			return r;
		end
	endfunction

endpackage
`default_nettype wire

/* hw/rtl/fud8_in_if.sv */
// Interface: input channel of the decoder (op and raw byte).
`default_nettype none
interface fud8_in_if;
	logic       valid;
	logic       ready;
	logic       op;
	logic [7:0] in_byte;

	modport source (output valid, output op, output in_byte, input ready);
	modport sink (input valid, input op, input in_byte, output ready);
endinterface
`default_nettype wire

/* hw/rtl/fud8_out_if.sv */
// Interface: result channel of the decoder.
`default_nettype none
interface fud8_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       has_byte;
	logic       done_res;
	logic [1:0] status;

	modport source (output valid, output out_byte, output has_byte, output done_res,
	                output status, input ready);
	modport sink (input valid, input out_byte, input has_byte, input done_res,
	              input status, output ready);
endinterface
`default_nettype wire

/* hw/rtl/fud8_step.sv */
// Module: next-state and result logic of the decoder for one request.
`default_nettype none
module fud8_step (
	input  fud8_pkg::state_t cur,
	input  logic             op,
	input  logic [7:0]       in_byte,
	output fud8_pkg::state_t nxt,
	output logic             res_vld,
	output fud8_pkg::res_t   res
);

	logic [4:0] hv;
	logic       emit;
	logic [7:0] eb;
	logic [1:0] derr_end;
	logic       uerr_end;

	assign hv = fud8_pkg::hex_value(in_byte);

	// escape handling and end of value
	always_comb begin
		nxt      = cur;
		emit     = 1'b0;
		eb       = in_byte;
		res_vld  = 1'b0;
		res      = '0;
		derr_end = cur.derr;
		uerr_end = cur.uerr;
		if (op == fud8_pkg::OP_END) begin
			if (cur.esc != fud8_pkg::ESC_NONE && derr_end == fud8_pkg::DERR_NONE) begin
				derr_end = fud8_pkg::DERR_ESC;
			end
			if (cur.pend != fud8_pkg::PEND_NONE) begin
				uerr_end = 1'b1;
			end
			res_vld      = 1'b1;
			res.done_res = 1'b1;
			case (derr_end)
				fud8_pkg::DERR_ESC:  res.status = fud8_pkg::ST_ESC;
				fud8_pkg::DERR_ZERO: res.status = fud8_pkg::ST_ZERO;
				default:             res.status = uerr_end ? fud8_pkg::ST_UTF8
				                                           : fud8_pkg::ST_OK;
			endcase
			nxt = '0;
		end else if (cur.esc == fud8_pkg::ESC_NONE) begin
			if (in_byte == fud8_pkg::CH_PERCENT) begin
				nxt.esc = fud8_pkg::ESC_PCT;
			end else begin
				emit = 1'b1;
				eb   = (in_byte == fud8_pkg::CH_PLUS) ? fud8_pkg::CH_SPACE : in_byte;
			end
		end else if (!hv[4]) begin
			// bad hex digit: drop the escape and the byte
			if (cur.derr == fud8_pkg::DERR_NONE) begin
				nxt.derr = fud8_pkg::DERR_ESC;
			end
			nxt.esc = fud8_pkg::ESC_NONE;
		end else if (cur.esc == fud8_pkg::ESC_PCT) begin
			nxt.hi  = hv[3:0];
			nxt.esc = fud8_pkg::ESC_HI;
		end else begin
			nxt.esc = fud8_pkg::ESC_NONE;
			emit    = 1'b1;
			eb      = {cur.hi, hv[3:0]};
		end

		// emitted byte: zero check and UTF-8 check
		if (emit) begin
			res_vld      = 1'b1;
			res.out_byte = eb;
			res.has_byte = 1'b1;
			if (eb == 8'd0 && cur.derr == fud8_pkg::DERR_NONE) begin
				nxt.derr = fud8_pkg::DERR_ZERO;
			end
			if (cur.pend != fud8_pkg::PEND_NONE) begin
				if ((eb & fud8_pkg::UTF_CONT_MASK) != fud8_pkg::UTF_CONT) begin
					nxt.uerr = 1'b1;
					nxt.pend = fud8_pkg::PEND_NONE;
				end else begin
					nxt.pend = cur.pend - 2'd1;
				end
			end else if (!eb[7]) begin
				nxt.pend = fud8_pkg::PEND_NONE;
			end else if ((eb & fud8_pkg::UTF_LEAD2_MASK) == fud8_pkg::UTF_LEAD2) begin
				if (eb < fud8_pkg::UTF_LEAD2_MIN) nxt.uerr = 1'b1;
				else nxt.pend = fud8_pkg::PEND_ONE;
			end else if ((eb & fud8_pkg::UTF_LEAD3_MASK) == fud8_pkg::UTF_LEAD3) begin
				nxt.pend = fud8_pkg::PEND_TWO;
			end else if ((eb & fud8_pkg::UTF_LEAD4_MASK) == fud8_pkg::UTF_LEAD4) begin
				nxt.pend = fud8_pkg::PEND_THR;
			end else begin
				nxt.uerr = 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

/* hw/rtl/form_urldecode_utf8_check_core.sv */
// Top level: form-urlencoded value decoder with UTF-8 check.
//
// One request a cycle: each request (data byte or end of value) is taken
// whenever the output skid stage is free, and the decoder state updates in
// that same cycle. A decoded byte or the end status is registered into the
// output register, or into the skid entry while it is full and not being read.
// The result side is an output register plus one skid entry, so input keeps
// flowing while a result waits; input stalls only when both are full.
// Escape prefixes, first hex digits and bad hex digits give no result. An
// end request returns a status (0 ok, 1 bad or truncated escape, 2 zero
// byte, 3 invalid UTF-8) and clears the state for the next value; a value
// with a nonzero status must be thrown away by the consumer.
`default_nettype none
module form_urldecode_utf8_check_core (
	input  wire           clk,
	input  wire           arst_n,
	fud8_in_if.sink       din,
	fud8_out_if.source    dout
);

	fud8_pkg::state_t state_q;
	fud8_pkg::state_t state_nxt;
	fud8_pkg::res_t   step_res;
	logic             step_vld;
	fud8_pkg::res_t   out_q;
	fud8_pkg::res_t   skid_q;
	logic             out_valid_q;
	logic             skid_valid_q;
	logic             acc;
	logic             push;
	logic             pop;

	fud8_step u_step (
		.cur     (state_q),
		.op      (din.op),
		.in_byte (din.in_byte),
		.nxt     (state_nxt),
		.res_vld (step_vld),
		.res     (step_res)
	);

	// handshakes
	assign din.ready = !skid_valid_q;
	assign acc       = din.valid && din.ready;
	assign push      = acc && step_vld;
	assign pop       = out_valid_q && dout.ready;

	// decoder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (acc) begin
			state_q <= state_nxt;
		end
	end

	// output register and skid entry: valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (pop) skid_valid_q <= 1'b0;
		end else if (push) begin
			if (out_valid_q && !pop) skid_valid_q <= 1'b1;
			else out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register and skid entry: payload
	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (pop) out_q <= skid_q;
		end else if (push) begin
			if (out_valid_q && !pop) skid_q <= step_res;
			else out_q <= step_res;
		end
	end

	assign dout.valid    = out_valid_q;
	assign dout.out_byte = out_q.out_byte;
	assign dout.has_byte = out_q.has_byte;
	assign dout.done_res = out_q.done_res;
	assign dout.status   = out_q.status;

`ifndef NO_ASSERTIONS
	// skid entry is only used behind a full output register
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry valid with empty output register");

	// an end request leaves the state cleared
	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && din.op == fud8_pkg::OP_END) |=> (state_q == '0))
		else $error("state not cleared after end of value");

	// end results carry no byte, byte results carry no status
	a_res_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_q.has_byte != out_q.done_res) &&
		(out_q.done_res || out_q.status == fud8_pkg::ST_OK))
		else $error("malformed result");

	// a percent outside an escape opens one and gives no result
	a_pct_opens: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && din.op == fud8_pkg::OP_DATA && state_q.esc == fud8_pkg::ESC_NONE &&
		 din.in_byte == fud8_pkg::CH_PERCENT) |-> !push ##1 (state_q.esc == fud8_pkg::ESC_PCT))
		else $error("percent did not open an escape");
`endif

endmodule
`default_nettype wire

/* sim/form_urldecode_utf8_check_core_tb.sv */
`timescale 1ns / 100ps
// Testbench: feeds encoded form values to the decoder and checks every result against a predictor.
module form_urldecode_utf8_check_core_tb;
	import fud8_pkg::*;

	localparam int RANDOM_REQS  = 1950;
	localparam int LIMIT_CYCLES = 200000;
	localparam int IDLE_PCT     = 28;

	// one request, with an optional typed-in result
	typedef struct {
		logic       op;
		logic [7:0] raw;
		bit         fixed;
		logic [7:0] want_byte;
		logic       want_has;
		logic       want_done;
		logic [1:0] want_status;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n;

	fud8_in_if  din_if ();
	fud8_out_if dout_if ();

	form_urldecode_utf8_check_core u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.din    (din_if),
		.dout   (dout_if)
	);

	always #2 clk = ~clk;

	// directed values: extremes, every special case, end right after reset
	stim_row_t directed_rows [28] = '{
		'{OP_END,  8'h00,      1'b1, 8'h00,    1'b0, 1'b1, ST_OK},   // empty value
		'{OP_DATA, CH_PLUS,    1'b1, CH_SPACE, 1'b1, 1'b0, ST_OK},
		'{OP_DATA, CH_PERCENT, 1'b0, 8'h00,    1'b0, 1'b0, ST_OK},
		'{OP_DATA, 8'h66,      1'b0, 8'h00,    1'b0, 1'b0, ST_OK},   // 'f'
		'{OP_DATA, 8'h46,      1'b1, 8'hFF,    1'b1, 1'b0, ST_OK},   // 'F' -> 0xFF
		'{OP_END,  8'hFF,      1'b1, 8'h00,    1'b0, 1'b1, ST_UTF8}, // raw byte ignored
		'{OP_DATA, CH_PERCENT, 1'b0, 8'h00,    1'b0, 1'b0, ST_OK},
		'{OP_DATA, 8'h30,      1'b0, 8'h00,    1'b0, 1'b0, ST_OK},
		'{OP_DATA, 8'h30,      1'b1, 8'h00,    1'b1, 1'b0, ST_OK},   // escaped zero
		'{OP_DATA, 8'hFF,      1'b1, 8'hFF,    1'b1, 1'b0, ST_OK},
		'{OP_END,  CH_PERCENT, 1'b1, 8'h00,    1'b0, 1'b1, ST_ZERO}, // zero over UTF-8
		'{OP_DATA, CH_PERCENT, 1'b0, 8'h00,    1'b0, 1'b0, ST_OK},
		'{OP_DATA, 8'h34,      1'b0, 8'h00,    1'b0, 1'b0, ST_OK},
		'{OP_DATA, 8'h67,      1'b0, 8'h00,    1'b0, 1'b0, ST_OK},   // 'g' is not hex
		'{OP_DATA, 8'h00,      1'b1, 8'h00,    1'b1, 1'b0, ST_OK},   // raw zero
		'{OP_END,  8'h00,      1'b1, 8'h00,    1'b0, 1'b1, ST_ESC},  // first error kept
		'{OP_DATA, CH_PERCENT, 1'b0, 8'h00,    1'b0, 1'b0, ST_OK},
		'{OP_END,  8'h00,      1'b1, 8'h00,    1'b0, 1'b1, ST_ESC},  // truncated escape
		'{OP_DATA, 8'hE2,      1'b1, 8'hE2,    1'b1, 1'b0, ST_OK},
		'{OP_DATA, 8'h41,      1'b1, 8'h41,    1'b1, 1'b0, ST_OK},   // bad continuation
		'{OP_END,  8'h00,      1'b1, 8'h00,    1'b0, 1'b1, ST_UTF8},
		'{OP_DATA, 8'hE2,      1'b1, 8'hE2,    1'b1, 1'b0, ST_OK},
		'{OP_END,  8'h00,      1'b1, 8'h00,    1'b0, 1'b1, ST_UTF8}, // truncated sequence
		'{OP_DATA, 8'hF0,      1'b0, 8'h00,    1'b0, 1'b0, ST_OK},   // valid 4-byte char
		'{OP_DATA, 8'h9F,      1'b0, 8'h00,    1'b0, 1'b0, ST_OK},
		'{OP_DATA, 8'h98,      1'b0, 8'h00,    1'b0, 1'b0, ST_OK},
		'{OP_DATA, 8'h80,      1'b0, 8'h00,    1'b0, 1'b0, ST_OK},
		'{OP_END,  8'h00,      1'b0, 8'h00,    1'b0, 1'b0, ST_OK}
	};

	stim_row_t stim_q [$];
	res_t      pending_results [$];
	int        sent_count = 0;
	int        mismatches = 0;
	logic      hold_off = 1'b0;
	logic      calm = 1'b0;

	// decoder state as predicted
	esc_t       esc_st;
	logic [3:0] hi_nib;
	logic [1:0] cont_left;
	logic [1:0] derr;
	logic       uerr;

	// ---------------------------------------------------------------- predictor

	function automatic int hex_digit(input logic [7:0] c);
		if (c >= CH_DIG_LO && c <= CH_DIG_HI) return int'(c - CH_DIG_LO);
		if (c >= CH_LCA_LO && c <= CH_LCA_HI) return int'(c - CH_LCA_LO) + 10;
		if (c >= CH_UCA_LO && c <= CH_UCA_HI) return int'(c - CH_UCA_LO) + 10;
		return -1;
	endfunction

	function automatic void clear_decoder();
		esc_st    = ESC_NONE;
		hi_nib    = '0;
		cont_left = PEND_NONE;
		derr      = DERR_NONE;
		uerr      = 1'b0;
	endfunction

	// lead class and continuation tracking of the decoded stream
	function automatic void track_utf8(input logic [7:0] b);
		if (cont_left != PEND_NONE) begin
			if ((b & UTF_CONT_MASK) != UTF_CONT) begin
				uerr      = 1'b1;
				cont_left = PEND_NONE;
			end else begin
				cont_left = cont_left - 2'd1;
			end
		end else if (b[7]) begin
			if ((b & UTF_LEAD2_MASK) == UTF_LEAD2) begin
				if (b < UTF_LEAD2_MIN) uerr = 1'b1;
				else cont_left = PEND_ONE;
			end else if ((b & UTF_LEAD3_MASK) == UTF_LEAD3) begin
				cont_left = PEND_TWO;
			end else if ((b & UTF_LEAD4_MASK) == UTF_LEAD4) begin
				cont_left = PEND_THR;
			end else begin
				uerr = 1'b1;
			end
		end
	endfunction

	function automatic res_t emit_decoded(input logic [7:0] b);
		res_t r;
		if (b == 8'h00 && derr == DERR_NONE) derr = DERR_ZERO;
		track_utf8(b);
		r          = '0;
		r.out_byte = b;
		r.has_byte = 1'b1;
		return r;
	endfunction

	// returns 1 when the request yields a result
	function automatic bit decode_request(input logic op, input logic [7:0] b,
	                                      output res_t r);
		int d;
		r = '0;
		if (op == OP_END) begin
			if (esc_st != ESC_NONE && derr == DERR_NONE) derr = DERR_ESC;
			if (cont_left != PEND_NONE) uerr = 1'b1;
			r.done_res = 1'b1;
			if (derr == DERR_ESC) r.status = ST_ESC;
			else if (derr == DERR_ZERO) r.status = ST_ZERO;
			else if (uerr) r.status = ST_UTF8;
			else r.status = ST_OK;
			clear_decoder();
			return 1'b1;
		end
		if (esc_st == ESC_NONE) begin
			if (b == CH_PERCENT) begin
				esc_st = ESC_PCT;
				return 1'b0;
			end
			r = emit_decoded((b == CH_PLUS) ? CH_SPACE : b);
			return 1'b1;
		end
		d = hex_digit(b);
		if (d < 0) begin
			if (derr == DERR_NONE) derr = DERR_ESC;
			esc_st = ESC_NONE;
			return 1'b0;
		end
		if (esc_st == ESC_PCT) begin
			hi_nib = d[3:0];
			esc_st = ESC_HI;
			return 1'b0;
		end
		esc_st = ESC_NONE;
		r = emit_decoded({hi_nib, d[3:0]});
		return 1'b1;
	endfunction

	// ---------------------------------------------------------------- stimulus

	task automatic add_req(input logic op, input logic [7:0] b);
		stim_q.push_back('{op, b, 1'b0, 8'h00, 1'b0, 1'b0, ST_OK});
	endtask

	function automatic logic [7:0] hex_char(input logic [3:0] n);
		if (n < 4'd10) return CH_DIG_LO + 8'(n);
		if ($urandom_range(0, 1)) return CH_UCA_LO + 8'(n - 4'd10);
		return CH_LCA_LO + 8'(n - 4'd10);
	endfunction

	function automatic logic [7:0] pick_non_hex();
		logic [7:0] b;
		do b = 8'($urandom_range(0, 255)); while (hex_digit(b) >= 0);
		return b;
	endfunction

	task automatic add_escape(input logic [7:0] b);
		add_req(OP_DATA, CH_PERCENT);
		add_req(OP_DATA, hex_char(b[7:4]));
		add_req(OP_DATA, hex_char(b[3:0]));
	endtask

	// literal percent and plus must be escaped; others at random
	task automatic add_encoded(input logic [7:0] b);
		if (b == CH_PERCENT || b == CH_PLUS || $urandom_range(0, 3) == 0) add_escape(b);
		else if (b == CH_SPACE && $urandom_range(0, 1)) add_req(OP_DATA, CH_PLUS);
		else add_req(OP_DATA, b);
	endtask

	// one well-formed character of 1 to 4 bytes
	task automatic add_char();
		int kind;
		int n_cont;
		kind   = $urandom_range(0, 9);
		n_cont = 0;
		if (kind < 5) begin
			add_encoded(8'($urandom_range('h20, 'h7E)));
		end else begin
			if (kind < 7) begin
				add_encoded(8'($urandom_range('hC2, 'hDF)));
				n_cont = 1;
			end else if (kind < 9) begin
				add_encoded(8'($urandom_range('hE0, 'hEF)));
				n_cont = 2;
			end else begin
				add_encoded(8'($urandom_range('hF0, 'hF7)));
				n_cont = 3;
			end
			repeat (n_cont) add_encoded(8'($urandom_range('h80, 'hBF)));
		end
	endtask

	// random bytes, broken escapes, stray continuations, refused leads, zero bytes
	task automatic add_noise();
		logic [7:0] bad;
		bad = pick_non_hex();
		case ($urandom_range(0, 5))
			0: add_req(OP_DATA, 8'($urandom_range(0, 255)));
			1: begin
				add_req(OP_DATA, CH_PERCENT);
				add_req(OP_DATA, bad);
			end
			2: begin
				add_req(OP_DATA, CH_PERCENT);
				add_req(OP_DATA, hex_char(4'($urandom_range(0, 15))));
				add_req(OP_DATA, bad);
			end
			3: add_encoded(8'($urandom_range('h80, 'hBF)));
			4: add_encoded($urandom_range(0, 1) ? 8'($urandom_range('hC0, 'hC1)) :
			                                      8'($urandom_range('hF8, 'hFF)));
			default: add_encoded(8'h00);
		endcase
	endtask

	// one value closed by an end request; a quarter of them are noisy
	task automatic add_value();
		int n_tok;
		bit noisy;
		n_tok = $urandom_range(0, 10);
		noisy = ($urandom_range(0, 3) == 0);
		repeat (n_tok) begin
			if (noisy && $urandom_range(0, 2) == 0) add_noise();
			else add_char();
		end
		if (noisy && $urandom_range(0, 1)) begin
			case ($urandom_range(0, 2))
				0: add_req(OP_DATA, CH_PERCENT);
				1: begin
					add_req(OP_DATA, CH_PERCENT);
					add_req(OP_DATA, hex_char(4'($urandom_range(0, 15))));
				end
				default: add_req(OP_DATA, 8'($urandom_range('hE0, 'hF7)));
			endcase
		end
		add_req(OP_END, 8'($urandom_range(0, 255)));
	endtask

	// ---------------------------------------------------------------- checking

	task automatic note_mismatch(input string what, input res_t want, input res_t got);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t: %s: expected byte=%02h has=%0b done=%0b status=%0d, got byte=%02h has=%0b done=%0b status=%0d",
			         $realtime, what, want.out_byte, want.has_byte, want.done_res, want.status,
			         got.out_byte, got.has_byte, got.done_res, got.status);
	endtask

	task automatic check_result(input res_t got);
		res_t want;
		if (pending_results.size() == 0) begin
			note_mismatch("unexpected result", '0, got);
			return;
		end
		want = pending_results.pop_front();
		if (got.out_byte !== want.out_byte || got.has_byte !== want.has_byte ||
		    got.done_res !== want.done_res || got.status !== want.status)
			note_mismatch("result mismatch", want, got);
	endtask

	// ---------------------------------------------------------------- drivers

	// request side: predict on acceptance, then offer the next request
	always @(posedge clk or negedge arst_n) begin : drive_requests
		bit   took;
		bit   got;
		res_t r;
		stim_row_t row;
		if (!arst_n) begin
			din_if.valid   <= 1'b0;
			din_if.op      <= OP_DATA;
			din_if.in_byte <= '0;
		end else begin
			took = din_if.valid && din_if.ready;
			if (took) begin
				row = stim_q[sent_count];
				got = decode_request(row.op, row.raw, r);
				if (row.fixed)
					pending_results.push_back({row.want_byte, row.want_has,
					                           row.want_done, row.want_status});
				else if (got)
					pending_results.push_back(r);
				sent_count++;
			end
			if (din_if.valid && !took) begin
				// hold the current request
			end else if (sent_count < stim_q.size() &&
			             (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
				din_if.valid   <= 1'b1;
				din_if.op      <= stim_q[sent_count].op;
				din_if.in_byte <= stim_q[sent_count].raw;
			end else begin
				din_if.valid <= 1'b0;
			end
		end
	end

	// result side: compare, then decide on ready
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dout_if.ready <= 1'b0;
		end else begin
			if (dout_if.valid && dout_if.ready)
				check_result({dout_if.out_byte, dout_if.has_byte, dout_if.done_res,
				              dout_if.status});
			dout_if.ready <= !hold_off && (calm || $urandom_range(0, 99) >= IDLE_PCT);
		end
	end

	// long receiver hold-off to fill the block, later a stretch with no idling
	initial begin
		while (sent_count < 400) @(posedge clk);
		hold_off <= 1'b1;
		repeat (160) @(posedge clk);
		hold_off <= 1'b0;
		while (sent_count < 1100) @(posedge clk);
		calm <= 1'b1;
		repeat (500) @(posedge clk);
		calm <= 1'b0;
	end

	// run limit
	initial begin : watchdog
		int cycles;
		cycles = 0;
		while (cycles < LIMIT_CYCLES) begin
			@(posedge clk);
			cycles++;
		end
		$display("Some tests failed");
		$finish;
	end

	// ---------------------------------------------------------------- sequence

	initial begin
		din_if.valid   = 1'b0;
		din_if.op      = OP_DATA;
		din_if.in_byte = '0;
		dout_if.ready  = 1'b0;
		arst_n         = 1'b0;
		clear_decoder();
		foreach (directed_rows[i]) stim_q.push_back(directed_rows[i]);
		while (stim_q.size() < $size(directed_rows) + RANDOM_REQS) add_value();

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (sent_count < stim_q.size()) @(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);

		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

/* filelist.f */
hw/rtl/fud8_pkg.sv
hw/rtl/fud8_in_if.sv
hw/rtl/fud8_out_if.sv
hw/rtl/fud8_step.sv
hw/rtl/form_urldecode_utf8_check_core.sv
sim/form_urldecode_utf8_check_core_tb.sv
